// ===== src/hof_pkg.sv =====
`default_nettype none
package hof_pkg;

  // Frame geometry
  localparam int FRAME_LENGTH = 64;
  localparam int HOP_LENGTH   = 32;

  // Ring index, fill counter and hop counter widths
  localparam int IDX_W = $clog2(FRAME_LENGTH);
  localparam int CNT_W = $clog2(FRAME_LENGTH + 1);
  localparam int HOP_W = $clog2(HOP_LENGTH + 1);

  // Fixed field widths
  localparam int SMP_W = 16;
  localparam int FRM_W = 16;
  localparam int POS_W = 6;
  localparam int WIN_W = 17;

  // Fixed point constants for the window table
  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1073741824;

  typedef logic [WIN_W-1:0] win_rom_t [FRAME_LENGTH];

  // Frame job handed from the front to the back
  typedef struct packed {
    logic [IDX_W-1:0] start;
    logic [FRM_W-1:0] frame;
  } desc_t;

  // Read progress of the back, seen by the front
  typedef struct packed {
    logic             busy;
    logic [IDX_W-1:0] start;
    logic [CNT_W-1:0] issued;
  } back_stat_t;

  // One result word
  typedef struct packed {
    logic signed [SMP_W-1:0] win;
    logic [FRM_W-1:0]        frame;
    logic [POS_W-1:0]        pos;
    logic                    last;
  } out_word_t;

  // Taylor series sine in Q30, truncating steps, clamped to [0, 1]
  // Terms divide by (2k)(2k+1) for k = 1..7, signs alternate
  function automatic longint unsigned sine_q30(longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    if (longint'(sum) > longint'(ONE_Q30)) begin
      sum = longint'(ONE_Q30);
    end
    return longint'(sum);
  endfunction

  // Periodic Hann window, unsigned Q1.16, built at elaboration
  function automatic win_rom_t build_win_rom();
    win_rom_t        rom;
    longint unsigned m;
    longint unsigned x;
    longint unsigned s;
    for (int n = 0; n < FRAME_LENGTH; n++) begin
      m = (2 * n <= FRAME_LENGTH) ? longint'(n) : longint'(FRAME_LENGTH - n);
      x = (PI_Q30 * m + longint'(FRAME_LENGTH / 2)) / FRAME_LENGTH;
      s = sine_q30(x);
      rom[n] = WIN_W'((s * s + (64'd1 << 43)) >> 44);
    end
    return rom;
  endfunction

  localparam win_rom_t HANN_ROM = build_win_rom();

endpackage
`default_nettype wire

// ===== src/hann_overlap_framer_unit.sv =====
// Channel  | Ports                                             | Dir
// ---------+---------------------------------------------------+-----
// input    | in_valid, in_ready, in_sample, in_last_in_block   | in
// result   | out_valid, out_ready, out_windowed_sample,        | out
//          | out_frame_number, out_position_in_frame,          |
//          | out_last_of_frame                                 |
//
// A sample word is taken on each accepted handshake. A completed frame gives FRAME_LENGTH
// result words, one per cycle at most, set by the single ring read port;
// with a hop of half a frame this averages two result words per input word.
// First result of a frame goes via job queue, ring read, product and buffer.
// Input stalls while a frame job waits in the queue, or while the write slot
// is still unread by the frame in progress. Synchronous active-low reset; the
// sample ring is not cleared and needs no clearing pass.
`default_nettype none
module hann_overlap_framer_unit
  import hof_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [SMP_W-1:0] in_sample,
  input  wire logic             in_last_in_block,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [SMP_W-1:0]      out_windowed_sample,
  output logic [FRM_W-1:0]      out_frame_number,
  output logic [POS_W-1:0]      out_position_in_frame,
  output logic                  out_last_of_frame
);

  back_stat_t       bstat;
  logic             q_empty;
  logic             q_valid;
  logic             q_push;
  logic             q_pop;
  desc_t            q_din;
  desc_t            q_dout;
  logic             ring_we;
  logic [IDX_W-1:0] ring_waddr;
  logic [SMP_W-1:0] ring_wdata;
  logic             ring_re;
  logic [IDX_W-1:0] ring_raddr;
  logic [SMP_W-1:0] ring_rdata;

  hof_ring u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .re    (ring_re),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  hof_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .in_last_in_block (in_last_in_block),
    .bstat            (bstat),
    .q_empty          (q_empty),
    .ring_we          (ring_we),
    .ring_waddr       (ring_waddr),
    .ring_wdata       (ring_wdata),
    .q_push           (q_push),
    .q_din            (q_din)
  );

  hof_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .valid (q_valid),
    .empty (q_empty),
    .dout  (q_dout)
  );

  hof_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_valid               (q_valid),
    .q_dout                (q_dout),
    .q_pop                 (q_pop),
    .bstat                 (bstat),
    .ring_re               (ring_re),
    .ring_raddr            (ring_raddr),
    .ring_rdata            (ring_rdata),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_windowed_sample   (out_windowed_sample),
    .out_frame_number      (out_frame_number),
    .out_position_in_frame (out_position_in_frame),
    .out_last_of_frame     (out_last_of_frame)
  );

  // no sample is written while a frame job still waits for the back
  a_no_write_with_job: assert property (@(posedge clk) disable iff (!rst_n)
    ring_we |-> q_empty)
    else $error("ring written while a frame job is queued");

  // a frame job is only queued on an accepted word
  a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (in_valid && in_ready))
    else $error("frame job pushed without an input word");

  // the read in progress never runs past the frame
  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bstat.busy |-> (bstat.issued < CNT_W'(FRAME_LENGTH)))
    else $error("frame read ran past its length");

  // a new frame job starts only after the previous one has been fully issued
  a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (bstat.busy && (bstat.issued == '0)))
    else $error("frame job not started cleanly");

endmodule
`default_nettype wire

// ===== src/hof_ring.sv =====
`default_nettype none
module hof_ring
  import hof_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [IDX_W-1:0] waddr,
  input  wire logic [SMP_W-1:0] wdata,
  input  wire logic             re,
  input  wire logic [IDX_W-1:0] raddr,
  output logic [SMP_W-1:0]      rdata
);

  logic [SMP_W-1:0] mem [FRAME_LENGTH];
  logic [SMP_W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== src/hof_front.sv =====
`default_nettype none
module hof_front
  import hof_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [SMP_W-1:0] in_sample,
  input  wire logic             in_last_in_block,
  input  wire back_stat_t       bstat,
  input  wire logic             q_empty,
  output logic                  ring_we,
  output logic [IDX_W-1:0]      ring_waddr,
  output logic [SMP_W-1:0]      ring_wdata,
  output logic                  q_push,
  output desc_t                 q_din
);

  logic [IDX_W-1:0] wp_r,     wp_nxt;
  logic [CNT_W-1:0] fill_r,   fill_nxt;
  logic [HOP_W-1:0] hop_r,    hop_nxt;
  logic [FRM_W-1:0] frames_r, frames_nxt;

  logic             accept;
  logic             slot_safe;
  logic [CNT_W-1:0] slot_gap;
  logic [IDX_W-1:0] wp_adv;
  logic [CNT_W-1:0] fill_inc;
  logic [HOP_W-1:0] hop_inc;
  logic             emit;

  // distance from the frame being read to the write slot
  always_comb begin
    if (wp_r >= bstat.start) begin
      slot_gap = CNT_W'(wp_r) - CNT_W'(bstat.start);
    end else begin
      slot_gap = CNT_W'(wp_r) + CNT_W'(FRAME_LENGTH) - CNT_W'(bstat.start);
    end
  end

  // a slot may be overwritten once the back has issued its read
  assign slot_safe = !bstat.busy || (slot_gap < bstat.issued);
  assign in_ready  = q_empty && slot_safe;
  assign accept    = in_valid && in_ready;

  assign ring_we    = accept;
  assign ring_waddr = wp_r;
  assign ring_wdata = in_sample;

  assign wp_adv   = (wp_r == IDX_W'(FRAME_LENGTH - 1)) ? '0 : wp_r + 1'b1;
  assign fill_inc = fill_r + 1'b1;
  assign hop_inc  = hop_r + 1'b1;

  // framing counters
  always_comb begin
    wp_nxt     = wp_r;
    fill_nxt   = fill_r;
    hop_nxt    = hop_r;
    frames_nxt = frames_r;
    emit       = 1'b0;
    if (accept) begin
      wp_nxt = wp_adv;
      if (fill_r < CNT_W'(FRAME_LENGTH)) begin
        fill_nxt = fill_inc;
        if (fill_inc == CNT_W'(FRAME_LENGTH)) begin
          emit    = 1'b1;
          hop_nxt = '0;
        end
      end else begin
        if (hop_inc >= HOP_W'(HOP_LENGTH)) begin
          emit    = 1'b1;
          hop_nxt = '0;
        end else begin
          hop_nxt = hop_inc;
        end
      end
      if (emit && (frames_r != '1)) begin
        frames_nxt = frames_r + 1'b1;
      end
      // restart after the last word of a block
      if (in_last_in_block) begin
        wp_nxt     = '0;
        fill_nxt   = '0;
        hop_nxt    = '0;
        frames_nxt = '0;
      end
    end
  end

  assign q_push      = emit;
  assign q_din.start = wp_adv;
  assign q_din.frame = frames_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r     <= '0;
      fill_r   <= '0;
      hop_r    <= '0;
      frames_r <= '0;
    end else begin
      wp_r     <= wp_nxt;
      fill_r   <= fill_nxt;
      hop_r    <= hop_nxt;
      frames_r <= frames_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/hof_queue.sv =====
`default_nettype none
module hof_queue
  import hof_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire desc_t din,
  input  wire logic  pop,
  output logic       valid,
  output logic       empty,
  output desc_t      dout
);

  desc_t       slot_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r,    cnt_nxt;
  logic        do_push;
  logic        do_pop;

  assign valid   = (cnt_r != 2'd0);
  assign empty   = (cnt_r == 2'd0);
  assign dout    = slot_r[rd_ptr_r];
  assign do_push = push && (cnt_r != 2'd2);
  assign do_pop  = pop && valid;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/hof_back.sv =====
`default_nettype none
module hof_back
  import hof_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_valid,
  input  wire desc_t            q_dout,
  output logic                  q_pop,
  output back_stat_t            bstat,
  output logic                  ring_re,
  output logic [IDX_W-1:0]      ring_raddr,
  input  wire logic [SMP_W-1:0] ring_rdata,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [SMP_W-1:0]      out_windowed_sample,
  output logic [FRM_W-1:0]      out_frame_number,
  output logic [POS_W-1:0]      out_position_in_frame,
  output logic                  out_last_of_frame
);

  localparam int OUT_DEPTH = 4;
  localparam int OPTR_W    = $clog2(OUT_DEPTH);
  localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);
  localparam int PROD_W    = SMP_W + WIN_W + 1;

  // frame sequencer
  logic             busy_r,  busy_nxt;
  logic [IDX_W-1:0] start_r, start_nxt;
  logic [FRM_W-1:0] frame_r, frame_nxt;
  logic [CNT_W-1:0] pos_r,   pos_nxt;
  logic [IDX_W-1:0] addr_r,  addr_nxt;
  logic             issue;
  logic [OCNT_W-1:0] occ;

  // stage 1: ring data arriving, weight and tags
  logic             s1_v_r;
  logic [WIN_W-1:0] s1_w_r;
  logic [FRM_W-1:0] s1_frame_r;
  logic [POS_W-1:0] s1_pos_r;
  logic             s1_last_r;

  // stage 2: product
  logic                     s2_v_r;
  logic signed [PROD_W-1:0] s2_prod_r;
  logic [FRM_W-1:0]         s2_frame_r;
  logic [POS_W-1:0]         s2_pos_r;
  logic                     s2_last_r;
  logic signed [PROD_W-1:0] rnd;

  // output buffer
  out_word_t         obuf_r [OUT_DEPTH];
  logic [OPTR_W-1:0] owr_r, ord_r;
  logic [OCNT_W-1:0] ocnt_r, ocnt_nxt;
  logic              opop;
  out_word_t         ohead;

  // words in flight plus words buffered bound the issue rate
  assign occ   = ocnt_r + OCNT_W'(s1_v_r) + OCNT_W'(s2_v_r);
  assign issue = busy_r && (occ < OCNT_W'(OUT_DEPTH));
  assign q_pop = !busy_r && q_valid;

  assign ring_re    = issue;
  assign ring_raddr = addr_r;

  assign bstat.busy   = busy_r;
  assign bstat.start  = start_r;
  assign bstat.issued = pos_r;

  // sequencer next state
  always_comb begin
    busy_nxt  = busy_r;
    start_nxt = start_r;
    frame_nxt = frame_r;
    pos_nxt   = pos_r;
    addr_nxt  = addr_r;
    if (q_pop) begin
      busy_nxt  = 1'b1;
      start_nxt = q_dout.start;
      frame_nxt = q_dout.frame;
      pos_nxt   = '0;
      addr_nxt  = q_dout.start;
    end else if (issue) begin
      pos_nxt  = pos_r + 1'b1;
      addr_nxt = (addr_r == IDX_W'(FRAME_LENGTH - 1)) ? '0 : addr_r + 1'b1;
      if (pos_r == CNT_W'(FRAME_LENGTH - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pos_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      pos_r  <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    frame_r <= frame_nxt;
    addr_r  <= addr_nxt;
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (issue) begin
      s1_w_r     <= HANN_ROM[pos_r[IDX_W-1:0]];
      s1_frame_r <= frame_r;
      s1_pos_r   <= POS_W'(pos_r);
      s1_last_r  <= (pos_r == CNT_W'(FRAME_LENGTH - 1));
    end
  end

  // stage 2: sample times weight
  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      s2_prod_r  <= PROD_W'($signed(ring_rdata) * $signed({1'b0, s1_w_r}));
      s2_frame_r <= s1_frame_r;
      s2_pos_r   <= s1_pos_r;
      s2_last_r  <= s1_last_r;
    end
  end

  // round half up to Q1.15
  assign rnd = s2_prod_r + PROD_W'(32768);

  // output buffer
  assign opop      = out_valid && out_ready;
  assign out_valid = (ocnt_r != '0);
  assign ohead     = obuf_r[ord_r];

  always_comb begin
    ocnt_nxt = ocnt_r;
    if (s2_v_r && !opop) begin
      ocnt_nxt = ocnt_r + 1'b1;
    end else if (!s2_v_r && opop) begin
      ocnt_nxt = ocnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      obuf_r[owr_r] <= '{win:   rnd[SMP_W+15:16],
                         frame: s2_frame_r,
                         pos:   s2_pos_r,
                         last:  s2_last_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_r  <= '0;
      ord_r  <= '0;
      ocnt_r <= '0;
    end else begin
      if (s2_v_r) begin
        owr_r <= owr_r + 1'b1;
      end
      if (opop) begin
        ord_r <= ord_r + 1'b1;
      end
      ocnt_r <= ocnt_nxt;
    end
  end

  assign out_windowed_sample   = ohead.win;
  assign out_frame_number      = ohead.frame;
  assign out_position_in_frame = ohead.pos;
  assign out_last_of_frame     = ohead.last;

endmodule
`default_nettype wire
